FILE: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/wsp_pkg.sv
// Shared constants and types of the world-to-screen projector.
package wsp_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int MATRIX_FRAC_DEF = 12;
    localparam int ENTRY_W         = 16;
    localparam int SIZE_W          = 14;
    localparam int SIZE_SHIFT      = 15;
    localparam int ONE_SHIFT       = 16;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 3;

    localparam logic [CFG_DATA_W-1:0] ROW0_RST = 64'h0000_0000_0000_1000;
    localparam logic [CFG_DATA_W-1:0] ROW1_RST = 64'h0000_0000_1000_0000;
    localparam logic [CFG_DATA_W-1:0] ROW2_RST = 64'h0000_1000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] ROW3_RST = 64'h1000_0000_0000_0000;
    localparam logic [SIZE_W-1:0]     WIDTH_RST  = 14'd1920;
    localparam logic [SIZE_W-1:0]     HEIGHT_RST = 14'd1080;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0   = 3'd0,
        REG_ROW1   = 3'd1,
        REG_ROW2   = 3'd2,
        REG_ROW3   = 3'd3,
        REG_WIDTH  = 3'd4,
        REG_HEIGHT = 3'd5,
        REG_CAMERA = 3'd6
    } wsp_reg_e;

    typedef struct packed {
        logic vis;
        logic neg_x;
        logic neg_y;
    } wsp_flags_t;

endpackage

FILE: sv/world_to_screen_projector.sv
// Top level of the world-to-screen projector: config, pipeline and output buffer.
// Usage:
//   Input channel s_*: one anchor per beat (base point, world offset, screen
//   offset, base_valid). Output channel m_*: one result per beat (visible,
//   screen_x, screen_y in Q.16 pixels, top-left origin, saturated; zeros when
//   hidden). Both channels use valid/ready.
//   Config: cfg_we/cfg_index/cfg_data write one register per cycle (matrix
//   rows 0..3, width, height, camera present); write only while idle.
// Timing:
//   An input beat passes three clip stages, three scaling stages, one
//   divider stage per quotient bit (COORD_WIDTH + 1) and the output register.
//   Throughput is one beat per cycle, set by the fully pipelined divider,
//   except while a full output buffer freezes the pipeline.
// Reset:
//   aresetn (synchronous, active low) empties the pipeline and loads the
//   identity matrix, a 1920x1080 viewport and no camera.
// Stall:
//   A two-entry output buffer keeps s_ready high while one result waits;
//   once both entries are full the pipeline freezes and s_ready drops.
module world_to_screen_projector #(
    parameter int COORD_WIDTH      = wsp_pkg::COORD_WIDTH_DEF,
    parameter int MATRIX_FRAC_BITS = wsp_pkg::MATRIX_FRAC_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [wsp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wsp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_base_valid,
    input  logic signed [COORD_WIDTH-1:0]     s_base_x,
    input  logic signed [COORD_WIDTH-1:0]     s_base_y,
    input  logic signed [COORD_WIDTH-1:0]     s_base_z,
    input  logic signed [COORD_WIDTH-1:0]     s_world_off_x,
    input  logic signed [COORD_WIDTH-1:0]     s_world_off_y,
    input  logic signed [COORD_WIDTH-1:0]     s_world_off_z,
    input  logic signed [COORD_WIDTH-1:0]     s_screen_off_x,
    input  logic signed [COORD_WIDTH-1:0]     s_screen_off_y,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_visible,
    output logic signed [COORD_WIDTH-1:0]     m_screen_x,
    output logic signed [COORD_WIDTH-1:0]     m_screen_y
);
    import wsp_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int CLIPW = CW + 18 - MATRIX_FRAC_BITS;
    localparam int DW    = CLIPW - 1;
    localparam int QB    = CW + 1;
    localparam int TW    = QB + 2;
    localparam logic signed [TW-1:0] MAXV = {{(TW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [TW-1:0] MINV = ~MAXV;

    logic [3:0][CFG_DATA_W-1:0] matrix_reg;
    logic [SIZE_W-1:0]          width_reg;
    logic [SIZE_W-1:0]          height_reg;
    logic                       camera_reg;

    logic en;

    logic                    c_valid, c_hidden;
    logic signed [CLIPW-1:0] c_x, c_y, c_w;
    logic signed [CW-1:0]    c_soff_x, c_soff_y;

    logic                    f_valid;
    wsp_flags_t              f_flags;
    logic [1:0]              f_ov;
    logic [1:0][DW-1:0]      f_rem;
    logic [1:0][QB-1:0]      f_lo;
    logic [DW-1:0]           f_w;
    logic signed [CW-1:0]    f_soff_x, f_soff_y;

    logic                    q_valid;
    wsp_flags_t              q_flags;
    logic [1:0]              q_ov;
    logic [1:0][QB-1:0]      q_quot;
    logic signed [CW-1:0]    q_soff_x, q_soff_y;

    logic [QB-1:0]           qmag[2];
    logic signed [TW-1:0]    qsgn[2];
    logic signed [TW-1:0]    tot[2];
    logic signed [CW-1:0]    res[2];
    logic                    neg[2];
    logic signed [CW-1:0]    soff[2];

    logic                    skid_valid_reg;
    logic                    skid_vis_reg;
    logic signed [CW-1:0]    skid_x_reg, skid_y_reg;
    logic                    m_valid_reg;
    logic                    m_vis_reg;
    logic signed [CW-1:0]    m_x_reg, m_y_reg;
    logic                    push, pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            matrix_reg[0] <= ROW0_RST;
            matrix_reg[1] <= ROW1_RST;
            matrix_reg[2] <= ROW2_RST;
            matrix_reg[3] <= ROW3_RST;
            width_reg     <= WIDTH_RST;
            height_reg    <= HEIGHT_RST;
            camera_reg    <= 1'b0;
        end else if (cfg_we) begin
            case (wsp_reg_e'(cfg_index))
                REG_ROW0:   matrix_reg[0] <= cfg_data;
                REG_ROW1:   matrix_reg[1] <= cfg_data;
                REG_ROW2:   matrix_reg[2] <= cfg_data;
                REG_ROW3:   matrix_reg[3] <= cfg_data;
                REG_WIDTH:  width_reg     <= cfg_data[SIZE_W-1:0];
                REG_HEIGHT: height_reg    <= cfg_data[SIZE_W-1:0];
                REG_CAMERA: camera_reg    <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    wsp_clip #(.CW(CW), .FRAC(MATRIX_FRAC_BITS)) u_clip (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_valid),
        .camera     (camera_reg),
        .matrix     (matrix_reg),
        .base_valid (s_base_valid),
        .base_x     (s_base_x),
        .base_y     (s_base_y),
        .base_z     (s_base_z),
        .off_x      (s_world_off_x),
        .off_y      (s_world_off_y),
        .off_z      (s_world_off_z),
        .soff_x     (s_screen_off_x),
        .soff_y     (s_screen_off_y),
        .out_valid  (c_valid),
        .out_hidden (c_hidden),
        .clip_x     (c_x),
        .clip_y     (c_y),
        .clip_w     (c_w),
        .out_soff_x (c_soff_x),
        .out_soff_y (c_soff_y)
    );

    wsp_scale #(.CW(CW), .FRAC(MATRIX_FRAC_BITS)) u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (c_valid),
        .hidden     (c_hidden),
        .clip_x     (c_x),
        .clip_y     (c_y),
        .clip_w     (c_w),
        .soff_x     (c_soff_x),
        .soff_y     (c_soff_y),
        .size_w     (width_reg),
        .size_h     (height_reg),
        .out_valid  (f_valid),
        .out_flags  (f_flags),
        .out_ov     (f_ov),
        .out_rem    (f_rem),
        .out_lo     (f_lo),
        .out_w      (f_w),
        .out_soff_x (f_soff_x),
        .out_soff_y (f_soff_y)
    );

    wsp_div #(.CW(CW), .FRAC(MATRIX_FRAC_BITS)) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (f_valid),
        .in_flags   (f_flags),
        .in_ov      (f_ov),
        .in_rem     (f_rem),
        .in_lo      (f_lo),
        .in_w       (f_w),
        .in_soff_x  (f_soff_x),
        .in_soff_y  (f_soff_y),
        .out_valid  (q_valid),
        .out_flags  (q_flags),
        .out_ov     (q_ov),
        .out_quot   (q_quot),
        .out_soff_x (q_soff_x),
        .out_soff_y (q_soff_y)
    );

    // sign, screen offset and saturation
    assign neg  = '{q_flags.neg_x, q_flags.neg_y};
    assign soff = '{q_soff_x, q_soff_y};

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            qmag[a] = q_ov[a] ? '1 : q_quot[a];
            qsgn[a] = neg[a] ? -$signed({2'b00, qmag[a]}) : $signed({2'b00, qmag[a]});
            tot[a]  = qsgn[a] + TW'(soff[a]);
            if (!q_flags.vis) begin
                res[a] = '0;
            end else if (tot[a] > MAXV) begin
                res[a] = MAXV[CW-1:0];
            end else if (tot[a] < MINV) begin
                res[a] = MINV[CW-1:0];
            end else begin
                res[a] = tot[a][CW-1:0];
            end
        end
    end

    assign push = en && q_valid;
    assign pop  = m_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (m_valid_reg && !pop) begin
                skid_valid_reg <= 1'b1;
            end else begin
                m_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                m_vis_reg <= skid_vis_reg;
                m_x_reg   <= skid_x_reg;
                m_y_reg   <= skid_y_reg;
            end
        end else if (push) begin
            if (m_valid_reg && !pop) begin
                skid_vis_reg <= q_flags.vis;
                skid_x_reg   <= res[0];
                skid_y_reg   <= res[1];
            end else begin
                m_vis_reg <= q_flags.vis;
                m_x_reg   <= res[0];
                m_y_reg   <= res[1];
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_visible  = m_vis_reg;
    assign m_screen_x = m_x_reg;
    assign m_screen_y = m_y_reg;

endmodule

FILE: sv/wsp_clip.sv
// World sum and 4x4 matrix transform to clip x, y and w.
module wsp_clip #(
    parameter int CW   = 32,
    parameter int FRAC = 12,
    localparam int CLIPW = CW + 18 - FRAC
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          en,
    input  logic                                          in_valid,
    input  logic                                          camera,
    input  logic [3:0][wsp_pkg::CFG_DATA_W-1:0]           matrix,
    input  logic                                          base_valid,
    input  logic signed [CW-1:0]                          base_x,
    input  logic signed [CW-1:0]                          base_y,
    input  logic signed [CW-1:0]                          base_z,
    input  logic signed [CW-1:0]                          off_x,
    input  logic signed [CW-1:0]                          off_y,
    input  logic signed [CW-1:0]                          off_z,
    input  logic signed [CW-1:0]                          soff_x,
    input  logic signed [CW-1:0]                          soff_y,
    output logic                                          out_valid,
    output logic                                          out_hidden,
    output logic signed [CLIPW-1:0]                       clip_x,
    output logic signed [CLIPW-1:0]                       clip_y,
    output logic signed [CLIPW-1:0]                       clip_w,
    output logic signed [CW-1:0]                          out_soff_x,
    output logic signed [CW-1:0]                          out_soff_y
);
    import wsp_pkg::*;

    localparam int PFW = CW + ENTRY_W;
    localparam int PRW = PFW - FRAC;

    logic signed [CW-1:0]  base_a[3];
    logic signed [CW-1:0]  off_a[3];
    logic signed [CW:0]    wsum[3];
    logic signed [CW-1:0]  v_next[3];
    logic signed [CW-1:0]  v_reg[3];
    logic                  a_valid_reg;
    logic                  a_hidden_reg;
    logic signed [CW-1:0]  a_soff_x_reg, a_soff_y_reg;

    logic signed [ENTRY_W-1:0] ent[4][3];
    logic signed [PFW-1:0]     prod[3][3];
    logic signed [PRW-1:0]     term_next[3][4];
    logic signed [PRW-1:0]     term_reg[3][4];
    logic                      b_valid_reg;
    logic                      b_hidden_reg;
    logic signed [CW-1:0]      b_soff_x_reg, b_soff_y_reg;

    logic signed [CLIPW-1:0]   clip_next[3];
    logic signed [CLIPW-1:0]   clip_reg[3];
    logic                      c_valid_reg;
    logic                      c_hidden_reg;
    logic signed [CW-1:0]      c_soff_x_reg, c_soff_y_reg;

    assign base_a = '{base_x, base_y, base_z};
    assign off_a  = '{off_x, off_y, off_z};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            wsum[i] = (CW+1)'(base_a[i]) + (CW+1)'(off_a[i]);
            if (wsum[i][CW] != wsum[i][CW-1]) begin
                v_next[i] = wsum[i][CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
            end else begin
                v_next[i] = wsum[i][CW-1:0];
            end
        end
    end

    // columns x, y and w of the matrix
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 3; c++) begin
                ent[r][c] = signed'(matrix[r][((c == 2) ? 3 : c) * ENTRY_W +: ENTRY_W]);
            end
        end
        for (int c = 0; c < 3; c++) begin
            for (int i = 0; i < 3; i++) begin
                prod[c][i]      = v_reg[i] * ent[i][c];
                term_next[c][i] = prod[c][i][PFW-1:FRAC];
            end
            term_next[c][3] = PRW'(ent[3][c]) <<< (ONE_SHIFT - FRAC);
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            clip_next[c] = CLIPW'(term_reg[c][0]) + CLIPW'(term_reg[c][1])
                         + CLIPW'(term_reg[c][2]) + CLIPW'(term_reg[c][3]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg        <= v_next;
            a_hidden_reg <= !(camera && base_valid);
            a_soff_x_reg <= soff_x;
            a_soff_y_reg <= soff_y;
            term_reg     <= term_next;
            b_hidden_reg <= a_hidden_reg;
            b_soff_x_reg <= a_soff_x_reg;
            b_soff_y_reg <= a_soff_y_reg;
            clip_reg     <= clip_next;
            c_hidden_reg <= b_hidden_reg;
            c_soff_x_reg <= b_soff_x_reg;
            c_soff_y_reg <= b_soff_y_reg;
        end
    end

    assign out_valid  = c_valid_reg;
    assign out_hidden = c_hidden_reg;
    assign clip_x     = clip_reg[0];
    assign clip_y     = clip_reg[1];
    assign clip_w     = clip_reg[2];
    assign out_soff_x = c_soff_x_reg;
    assign out_soff_y = c_soff_y_reg;

endmodule

FILE: sv/wsp_scale.sv
// Viewport numerators, size scaling and divider setup with overflow check.
module wsp_scale #(
    parameter int CW   = 32,
    parameter int FRAC = 12,
    localparam int CLIPW = CW + 18 - FRAC,
    localparam int DW    = CLIPW - 1,
    localparam int QB    = CW + 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic                            hidden,
    input  logic signed [CLIPW-1:0]         clip_x,
    input  logic signed [CLIPW-1:0]         clip_y,
    input  logic signed [CLIPW-1:0]         clip_w,
    input  logic signed [CW-1:0]            soff_x,
    input  logic signed [CW-1:0]            soff_y,
    input  logic [wsp_pkg::SIZE_W-1:0]      size_w,
    input  logic [wsp_pkg::SIZE_W-1:0]      size_h,
    output logic                            out_valid,
    output wsp_pkg::wsp_flags_t             out_flags,
    output logic [1:0]                      out_ov,
    output logic [1:0][DW-1:0]              out_rem,
    output logic [1:0][QB-1:0]              out_lo,
    output logic [DW-1:0]                   out_w,
    output logic signed [CW-1:0]            out_soff_x,
    output logic signed [CW-1:0]            out_soff_y
);
    import wsp_pkg::*;

    localparam int MW = CLIPW + 1;
    localparam int RW = MW + SIZE_W;
    localparam int PW = RW + SIZE_SHIFT;

    logic signed [MW-1:0] num[2];
    logic [MW-1:0]        mag_next[2];
    wsp_flags_t           flags_next;
    logic                 vis;

    logic                 d_valid_reg;
    wsp_flags_t           d_flags_reg;
    logic [MW-1:0]        d_mag_reg[2];
    logic [DW-1:0]        d_w_reg;
    logic signed [CW-1:0] d_soff_x_reg, d_soff_y_reg;

    logic                 e_valid_reg;
    wsp_flags_t           e_flags_reg;
    logic [RW-1:0]        e_prod_reg[2];
    logic [DW-1:0]        e_w_reg;
    logic signed [CW-1:0] e_soff_x_reg, e_soff_y_reg;

    logic [PW-1:0]        pnum[2];
    logic [PW-1:0]        phi[2];
    logic [1:0]           ov_next;
    logic [1:0][DW-1:0]   rem_next;
    logic [1:0][QB-1:0]   lo_next;

    logic                 f_valid_reg;
    wsp_flags_t           f_flags_reg;
    logic [1:0]           f_ov_reg;
    logic [1:0][DW-1:0]   f_rem_reg;
    logic [1:0][QB-1:0]   f_lo_reg;
    logic [DW-1:0]        f_w_reg;
    logic signed [CW-1:0] f_soff_x_reg, f_soff_y_reg;

    always_comb begin
        num[0] = MW'(clip_x) + MW'(clip_w);
        num[1] = MW'(clip_w) - MW'(clip_y);
        vis    = !hidden && (clip_w > 0);
        for (int a = 0; a < 2; a++) begin
            mag_next[a] = num[a][MW-1] ? MW'(-num[a]) : MW'(num[a]);
        end
        flags_next.vis   = vis;
        flags_next.neg_x = num[0][MW-1];
        flags_next.neg_y = num[1][MW-1];
    end

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            pnum[a]     = {e_prod_reg[a], {SIZE_SHIFT{1'b0}}};
            phi[a]      = pnum[a] >> QB;
            ov_next[a]  = phi[a] >= PW'(e_w_reg);
            rem_next[a] = ov_next[a] ? '0 : phi[a][DW-1:0];
            lo_next[a]  = pnum[a][QB-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end else if (en) begin
            d_valid_reg <= in_valid;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_flags_reg   <= flags_next;
            d_mag_reg     <= mag_next;
            d_w_reg       <= vis ? clip_w[DW-1:0] : DW'(1);
            d_soff_x_reg  <= soff_x;
            d_soff_y_reg  <= soff_y;
            e_flags_reg   <= d_flags_reg;
            e_prod_reg[0] <= d_mag_reg[0] * size_w;
            e_prod_reg[1] <= d_mag_reg[1] * size_h;
            e_w_reg       <= d_w_reg;
            e_soff_x_reg  <= d_soff_x_reg;
            e_soff_y_reg  <= d_soff_y_reg;
            f_flags_reg   <= e_flags_reg;
            f_ov_reg      <= ov_next;
            f_rem_reg     <= rem_next;
            f_lo_reg      <= lo_next;
            f_w_reg       <= e_w_reg;
            f_soff_x_reg  <= e_soff_x_reg;
            f_soff_y_reg  <= e_soff_y_reg;
        end
    end

    assign out_valid  = f_valid_reg;
    assign out_flags  = f_flags_reg;
    assign out_ov     = f_ov_reg;
    assign out_rem    = f_rem_reg;
    assign out_lo     = f_lo_reg;
    assign out_w      = f_w_reg;
    assign out_soff_x = f_soff_x_reg;
    assign out_soff_y = f_soff_y_reg;

endmodule

FILE: sv/wsp_div.sv
// Pipelined restoring divider, one quotient bit per stage, both axes.
module wsp_div #(
    parameter int CW   = 32,
    parameter int FRAC = 12,
    localparam int CLIPW = CW + 18 - FRAC,
    localparam int DW    = CLIPW - 1,
    localparam int QB    = CW + 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  wsp_pkg::wsp_flags_t     in_flags,
    input  logic [1:0]              in_ov,
    input  logic [1:0][DW-1:0]      in_rem,
    input  logic [1:0][QB-1:0]      in_lo,
    input  logic [DW-1:0]           in_w,
    input  logic signed [CW-1:0]    in_soff_x,
    input  logic signed [CW-1:0]    in_soff_y,
    output logic                    out_valid,
    output wsp_pkg::wsp_flags_t     out_flags,
    output logic [1:0]              out_ov,
    output logic [1:0][QB-1:0]      out_quot,
    output logic signed [CW-1:0]    out_soff_x,
    output logic signed [CW-1:0]    out_soff_y
);
    import wsp_pkg::*;

    typedef struct packed {
        wsp_flags_t           flags;
        logic [1:0]           ov;
        logic [1:0][DW-1:0]   rem;
        logic [1:0][QB-1:0]   lo;
        logic [DW-1:0]        w;
        logic signed [CW-1:0] soff_x;
        logic signed [CW-1:0] soff_y;
    } stage_t;

    function automatic stage_t div_step(stage_t s);
        stage_t       r;
        logic [DW:0]  t;
        r = s;
        for (int a = 0; a < 2; a++) begin
            t = {s.rem[a], s.lo[a][QB-1]};
            if (t >= {1'b0, s.w}) begin
                r.rem[a] = DW'(t - {1'b0, s.w});
                r.lo[a]  = {s.lo[a][QB-2:0], 1'b1};
            end else begin
                r.rem[a] = t[DW-1:0];
                r.lo[a]  = {s.lo[a][QB-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    stage_t in_stage;
    stage_t stage_reg[1:QB];
    logic   valid_reg[1:QB];

    assign in_stage.flags  = in_flags;
    assign in_stage.ov     = in_ov;
    assign in_stage.rem    = in_rem;
    assign in_stage.lo     = in_lo;
    assign in_stage.w      = in_w;
    assign in_stage.soff_x = in_soff_x;
    assign in_stage.soff_y = in_soff_y;

    for (genvar k = 0; k < QB; k++) begin : g_stage
        stage_t src;
        logic   src_valid;
        if (k == 0) begin : g_first
            assign src       = in_stage;
            assign src_valid = in_valid;
        end else begin : g_next
            assign src       = stage_reg[k];
            assign src_valid = valid_reg[k];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                valid_reg[k+1] <= src_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                stage_reg[k+1] <= div_step(src);
            end
        end
    end

    assign out_valid  = valid_reg[QB];
    assign out_flags  = stage_reg[QB].flags;
    assign out_ov     = stage_reg[QB].ov;
    assign out_quot   = stage_reg[QB].lo;
    assign out_soff_x = stage_reg[QB].soff_x;
    assign out_soff_y = stage_reg[QB].soff_y;

endmodule

FILE: sv/wsp_checker.sv
// Port-level checks of the world-to-screen projector, bound to the top level.
`include "assert_macros.svh"

module wsp_checker #(
    parameter int COORD_WIDTH = 32
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_visible,
    input logic signed [COORD_WIDTH-1:0] m_screen_x,
    input logic signed [COORD_WIDTH-1:0] m_screen_y
);

    `ASSERT_CLK(a_hidden_zero, aclk, aresetn, (m_valid && !m_visible) |-> (m_screen_x == '0 && m_screen_y == '0), "hidden beat with nonzero coordinates")
    `ASSERT_CLK(a_out_hold, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_visible) && $stable(m_screen_x) && $stable(m_screen_y)), "stalled result beat changed")
    `ASSERT_CLK(a_ready_fall, aclk, aresetn, $fell(s_ready) |-> $past(m_valid && !m_ready), "input stalled without output backpressure")
    `ASSERT_CLK(a_full_has_head, aclk, aresetn, !s_ready |-> m_valid, "input stalled with no result pending")

endmodule

bind world_to_screen_projector wsp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_wsp_checker (.*);

FILE: dv/world_to_screen_projector_tb.sv
// Testbench for world_to_screen_projector: directed and random anchors checked against a predictor.
`timescale 1ns / 1ps

module world_to_screen_projector_tb;
    import wsp_pkg::*;

    localparam int CW = 32;
    localparam int FRAC = 12;
    localparam int LATENCY = CW + 8;

    typedef struct packed {
        logic                 base_valid;
        logic signed [CW-1:0] bx, by, bz, ox, oy, oz, sox, soy;
    } anchor_t;

    typedef struct packed {
        logic                 vis;
        logic signed [CW-1:0] sx, sy;
    } pixel_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    anchor_t s_item = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_visible;
    logic signed [CW-1:0] m_screen_x, m_screen_y;

    logic [63:0] mat_rows [4];
    logic [SIZE_W-1:0] view_w, view_h;
    logic cam_on;

    pixel_t pending_pixels [$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    world_to_screen_projector dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_base_valid(s_item.base_valid),
        .s_base_x(s_item.bx), .s_base_y(s_item.by), .s_base_z(s_item.bz),
        .s_world_off_x(s_item.ox), .s_world_off_y(s_item.oy),
        .s_world_off_z(s_item.oz),
        .s_screen_off_x(s_item.sox), .s_screen_off_y(s_item.soy),
        .m_valid(m_valid), .m_ready(m_ready), .m_visible(m_visible),
        .m_screen_x(m_screen_x), .m_screen_y(m_screen_y)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic signed [127:0] sat_coord(logic signed [127:0] v);
        logic signed [127:0] hi, lo;
        hi = (128'sd1 <<< (CW - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic logic signed [127:0] scale_axis(logic signed [127:0] num,
            logic signed [127:0] w, logic [SIZE_W-1:0] size);
        logic [127:0] mag, q;
        mag = num < 0 ? -num : num;
        q = (mag * {size, 15'b0}) / w;
        if (q > (128'd1 << 62))
            q = 128'd1 << 62;
        return num < 0 ? -$signed(q) : $signed(q);
    endfunction

    function automatic pixel_t project(anchor_t a);
        logic signed [127:0] pt [4];
        logic signed [127:0] clip [4];
        logic signed [15:0] coef;
        logic signed [127:0] sx, sy;
        pixel_t p;
        p = '0;
        if (!cam_on || !a.base_valid)
            return p;
        pt[0] = sat_coord(128'(a.bx) + 128'(a.ox));
        pt[1] = sat_coord(128'(a.by) + 128'(a.oy));
        pt[2] = sat_coord(128'(a.bz) + 128'(a.oz));
        pt[3] = 128'sd65536;
        for (int j = 0; j < 4; j++) begin
            clip[j] = 0;
            for (int i = 0; i < 4; i++) begin
                coef = mat_rows[i][16*j +: 16];
                clip[j] += (pt[i] * 128'(coef)) >>> FRAC;
            end
        end
        if (clip[3] <= 0)
            return p;
        sx = sat_coord(scale_axis(clip[0] + clip[3], clip[3], view_w) + 128'(a.sox));
        sy = sat_coord(scale_axis(clip[3] - clip[1], clip[3], view_h) + 128'(a.soy));
        p.vis = 1'b1;
        p.sx = sx[CW-1:0];
        p.sy = sy[CW-1:0];
        return p;
    endfunction

    task automatic write_reg(wsp_reg_e idx, logic [63:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ROW0, REG_ROW1, REG_ROW2, REG_ROW3: mat_rows[idx] = val;
            REG_WIDTH: view_w = val[SIZE_W-1:0];
            REG_HEIGHT: view_h = val[SIZE_W-1:0];
            default: cam_on = val[0];
        endcase
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
        @(negedge aclk);
    endtask

    // entered and left at a falling edge so beats can follow back to back
    task automatic send_anchor(anchor_t a);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < send_idle_pct)
                @(negedge aclk);
        end
        s_item <= a;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_pixels.push_back(project(a));
        @(negedge aclk);
    endtask

    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge aclk) begin
        pixel_t exp_p;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                exp_p = pending_pixels.pop_front();
                if (m_visible !== exp_p.vis) begin
                    $error("visible: expected %0d got %0d", exp_p.vis, m_visible);
                    errors++;
                end
                if (m_screen_x !== exp_p.sx) begin
                    $error("screen_x: expected %0d got %0d", exp_p.sx, m_screen_x);
                    errors++;
                end
                if (m_screen_y !== exp_p.sy) begin
                    $error("screen_y: expected %0d got %0d", exp_p.sy, m_screen_y);
                    errors++;
                end
            end
        end
    end

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(5))
            0: return {1'b0, {(CW-1){1'b1}}};
            1: return {1'b1, {(CW-1){1'b0}}};
            2: return $urandom;
            default: return $signed($urandom_range(0, 2 * (200 << 16))) - (200 << 16);
        endcase
    endfunction

    function automatic anchor_t rand_anchor();
        anchor_t a;
        a.base_valid = ($urandom_range(9) != 0);
        a.bx = rand_coord(); a.by = rand_coord(); a.bz = rand_coord();
        a.ox = rand_coord(); a.oy = rand_coord(); a.oz = rand_coord();
        a.sox = rand_coord(); a.soy = rand_coord();
        return a;
    endfunction

    function automatic logic [15:0] rand_entry();
        case ($urandom_range(4))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    task automatic randomize_camera();
        for (int r = 0; r < 4; r++)
            write_reg(wsp_reg_e'(r), {rand_entry(), rand_entry(), rand_entry(), rand_entry()});
        // keep w mostly positive
        if ($urandom_range(3) != 0)
            write_reg(REG_ROW3, {16'h1000, rand_entry(), rand_entry(), rand_entry()});
        write_reg(REG_WIDTH, 64'($urandom_range(1, 8192)));
        write_reg(REG_HEIGHT, 64'($urandom_range(1, 8192)));
    endtask

    task automatic test_no_camera();
        anchor_t a;
        write_reg(REG_CAMERA, 64'd0);
        repeat (3) begin
            a = rand_anchor();
            a.base_valid = 1'b1;
            send_anchor(a);
        end
        drain();
    endtask

    task automatic test_directed();
        anchor_t a;
        write_reg(REG_CAMERA, 64'd1);
        a = '0;
        a.base_valid = 1'b1;
        send_anchor(a);
        a.bx = 32'sh0000_8000; a.by = -32'sh0000_8000; a.sox = 32'sh0001_0000;
        send_anchor(a);
        a.base_valid = 1'b0;
        send_anchor(a);
        a = '0; a.base_valid = 1'b1;
        a.bx = {1'b0, {31{1'b1}}}; a.ox = a.bx; a.by = {1'b1, 31'b0}; a.oy = a.by;
        a.sox = {1'b0, {31{1'b1}}}; a.soy = {1'b1, 31'b0};
        send_anchor(a);
        a = '0; a.base_valid = 1'b1;
        a.bx = '1; a.by = '1; a.bz = '1; a.ox = '1; a.oy = '1; a.oz = '1;
        a.sox = '1; a.soy = '1;
        send_anchor(a);
        drain();
        write_reg(REG_WIDTH, 64'd0);
        write_reg(REG_HEIGHT, 64'd8192);
        a = '0; a.base_valid = 1'b1; a.bx = 32'sh0000_4000; a.sox = 32'sh0000_0123;
        send_anchor(a);
        drain();
        write_reg(REG_WIDTH, 64'd8192);
        write_reg(REG_HEIGHT, 64'd1);
        send_anchor(a);
        drain();
        // w of zero and negative w: hidden
        write_reg(REG_ROW3, 64'h0000_0000_0000_0000);
        send_anchor(a);
        drain();
        write_reg(REG_ROW3, 64'hf000_0000_0000_0000);
        send_anchor(a);
        drain();
        // extreme entries: the second anchor has tiny w and a huge numerator (quotient clamp)
        write_reg(REG_ROW3, 64'h0001_0000_0000_0000);
        write_reg(REG_ROW0, 64'h7fff_7fff_7fff_7fff);
        write_reg(REG_ROW1, 64'h0000_8000_8000_8000);
        write_reg(REG_ROW2, 64'h7fff_8000_7fff_8000);
        a = '0; a.base_valid = 1'b1; a.bx = {1'b0, {31{1'b1}}}; a.by = {1'b1, 31'b0};
        send_anchor(a);
        a.bx = {1'b1, 31'b0}; a.bz = {1'b0, {31{1'b1}}};
        send_anchor(a);
        drain();
    endtask

    task automatic test_random(int n);
        for (int k = 0; k < n; k++) begin
            if (k % 50 == 0) begin
                drain();
                randomize_camera();
            end
            send_anchor(rand_anchor());
        end
        drain();
    endtask

    initial begin
        mat_rows[0] = ROW0_RST; mat_rows[1] = ROW1_RST;
        mat_rows[2] = ROW2_RST; mat_rows[3] = ROW3_RST;
        view_w = WIDTH_RST; view_h = HEIGHT_RST; cam_on = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_no_camera();
        test_directed();
        write_reg(REG_CAMERA, 64'd1);
        send_idle_pct = 14; recv_idle_pct = 81;
        test_random(250);
        send_idle_pct = 81; recv_idle_pct = 14;
        test_random(250);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(250);
        test_no_camera();
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
